FILE: rtl/core/rtp_pkg.sv
// Package for the right-truncatable prime checker: shared constants and types.
package rtp_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int RADIX          = 10;
    localparam int FIRST_DIVISOR  = 2;
    localparam int OUT_BYTES_W    = 8;

    typedef struct packed {
        logic busy;
        logic done;
    } rtp_div_stat_t;

endpackage

FILE: rtl/core/rtp_div.sv
// Restoring divider, one quotient bit per cycle; gives the remainder.
module rtp_div #(
    parameter int VALUE_BITS = rtp_pkg::VALUE_BITS_DEF,
    parameter int DIV_BITS   = VALUE_BITS / 2 + 2
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [VALUE_BITS-1:0]     dividend,
    input  logic [DIV_BITS-1:0]       divisor,
    output rtp_pkg::rtp_div_stat_t    stat,
    output logic [DIV_BITS-1:0]       remainder
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [DIV_BITS-1:0]   rem_reg, rem_next;
    logic [DIV_BITS-1:0]   d_reg, d_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_BITS:0]     trial;
    logic                  fits;

    assign trial = {rem_reg, q_reg[VALUE_BITS-1]};
    assign fits  = (trial >= {1'b0, d_reg});

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            d_next    = divisor;
            cnt_next  = CNT_W'(VALUE_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = DIV_BITS'(trial - {1'b0, d_reg});
            end
            else
            begin
                rem_next = DIV_BITS'(trial);
            end
            q_next   = {q_reg[VALUE_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/core/right_truncatable_prime_check.sv
// Top level: trial-division prime and right-truncatable prime checker.
//
// channel  dir  tdata fields (lowest bit up)
// s_*      in   value[VALUE_BITS-1:0], zero fill to bytes
// m_*      out  is_prime, is_right_truncatable, zero fill to 8 bits
//
// Each trial divisor costs one pass of the shared divider plus a bound check;
// each decimal truncation is a shift-and-add divide by ten after that check.
// No input is taken while an item is in work; a new input is taken while the
// previous result still waits on m_tready. Reset clears the FSM and valid flags.
module right_truncatable_prime_check #(
    parameter int VALUE_BITS = rtp_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,  // value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rtp_pkg::OUT_BYTES_W-1:0]     m_tdata   // is_prime, is_right_truncatable
);

    localparam int DIV_BITS = VALUE_BITS / 2 + 2;
    localparam int SQ_BITS  = VALUE_BITS + 1;

    localparam logic [2:0] TSTEP_SHIFT = 3'd4;
    localparam logic [2:0] TSTEP_REM   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_CHECK,
        ST_MOD,
        ST_TRUNC,
        ST_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   n_reg, n_next;
    logic [DIV_BITS-1:0]     d_reg, d_next;
    logic [SQ_BITS-1:0]      sq_reg, sq_next;
    logic [VALUE_BITS-1:0]   tq_reg, tq_next;
    logic [VALUE_BITS-1:0]   tr_reg, tr_next;
    logic [2:0]              tstep_reg, tstep_next;
    logic                    first_reg, first_next;
    logic                    prime_reg, prime_next;
    logic                    trunc_reg, trunc_next;
    logic                    ovalid_reg, ovalid_next;
    logic [1:0]              odata_reg, odata_next;

    logic                    div_start;
    logic [DIV_BITS-1:0]     div_divisor;
    rtp_pkg::rtp_div_stat_t  div_stat;
    logic [DIV_BITS-1:0]     div_rem;

    rtp_div #(
        .VALUE_BITS (VALUE_BITS),
        .DIV_BITS   (DIV_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        d_next      = d_reg;
        sq_next     = sq_reg;
        tq_next     = tq_reg;
        tr_next     = tr_reg;
        tstep_next  = tstep_reg;
        first_next  = first_reg;
        prime_next  = prime_reg;
        trunc_next  = trunc_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        div_start   = 1'b0;
        div_divisor = d_reg;

        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    n_next     = s_tdata[VALUE_BITS-1:0];
                    first_next = 1'b1;
                    prime_next = 1'b1;
                    trunc_next = 1'b0;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                d_next  = DIV_BITS'(rtp_pkg::FIRST_DIVISOR);
                sq_next = SQ_BITS'(rtp_pkg::FIRST_DIVISOR * rtp_pkg::FIRST_DIVISOR);
                if (n_reg < VALUE_BITS'(rtp_pkg::FIRST_DIVISOR))
                begin
                    if (first_reg)
                    begin
                        prime_next = 1'b0;
                    end
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sq_reg > {1'b0, n_reg})
                begin
                    tq_next    = (n_reg >> 1) + (n_reg >> 2);
                    tstep_next = '0;
                    state_next = ST_TRUNC;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (div_stat.done)
                begin
                    if (div_rem == '0)
                    begin
                        if (first_reg)
                        begin
                            prime_next = 1'b0;
                        end
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        d_next     = d_reg + 1'b1;
                        sq_next    = sq_reg + SQ_BITS'({d_reg, 1'b1});
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_TRUNC:
            begin
                // divide by ten: 0.8 * n by shift-and-add, then one remainder fix-up
                tstep_next = tstep_reg + 1'b1;
                if (tstep_reg < TSTEP_SHIFT)
                begin
                    tq_next = tq_reg + (tq_reg >> (6'd4 << tstep_reg));
                end
                else if (tstep_reg == TSTEP_SHIFT)
                begin
                    tq_next = tq_reg >> 3;
                end
                else if (tstep_reg == TSTEP_REM)
                begin
                    tr_next = n_reg - ((tq_reg << 3) + (tq_reg << 1));
                end
                else
                begin
                    first_next = 1'b0;
                    if (tr_reg > VALUE_BITS'(rtp_pkg::RADIX - 1))
                    begin
                        n_next     = tq_reg + 1'b1;
                        state_next = ST_START;
                    end
                    else if (tq_reg == '0)
                    begin
                        trunc_next = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        n_next     = tq_reg;
                        state_next = ST_START;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {trunc_reg, prime_reg};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        tq_reg    <= tq_next;
        tr_reg    <= tr_next;
        tstep_reg <= tstep_next;
        first_reg <= first_next;
        prime_reg <= prime_next;
        trunc_reg <= trunc_next;
        odata_reg <= odata_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {{(rtp_pkg::OUT_BYTES_W - 2){1'b0}}, odata_reg};

endmodule

FILE: tb/sv/tb_right_truncatable_prime_check.sv
// Testbench for the right-truncatable prime checker: stream stimulus and self-checking scoreboard.
`timescale 1ns / 100ps

module tb_right_truncatable_prime_check;

    localparam int VALUE_BITS    = rtp_pkg::VALUE_BITS_DEF;
    localparam int S_DATA_W      = ((VALUE_BITS + 7) / 8) * 8;
    localparam int RANDOM_VALUES = 100;
    localparam int IDLE_LIMIT    = 1_500_000;
    localparam int DRAIN_CYCLES  = 200;

    localparam logic [VALUE_BITS-1:0] CORNER_VALUES [24] = '{
        0, 1, 2, 3, 4, 5, 9, 19, 23, 25, 29, 37, 49, 53, 73, 97, 233, 2333,
        739399, 7393933, 1000000, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF
    };
    localparam int unsigned LEAD_DIGITS [4] = '{2, 3, 5, 7};
    localparam int unsigned TAIL_DIGITS [4] = '{1, 3, 7, 9};

    typedef struct packed {
        bit is_prime;
        bit is_right_truncatable;
    } verdict_t;

    class prime_scoreboard;
        verdict_t    awaited[$];
        int unsigned mismatches;

        static function bit trial_division_prime(longint unsigned n);
            longint unsigned d;
            if (n < 2)
                return 1'b0;
            for (d = 2; d <= n / d; d++)
            begin
                if (n % d == 0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        static function bit all_truncations_prime(longint unsigned n);
            if (n == 0)
                return 1'b0;
            while (n != 0)
            begin
                if (!trial_division_prime(n))
                    return 1'b0;
                n = n / 10;
            end
            return 1'b1;
        endfunction

        function void note_value(logic [VALUE_BITS-1:0] v);
            verdict_t vd;
            vd.is_prime             = trial_division_prime(v);
            vd.is_right_truncatable = vd.is_prime && all_truncations_prime(v);
            awaited.push_back(vd);
        endfunction

        function void check_verdict(logic [rtp_pkg::OUT_BYTES_W-1:0] data);
            verdict_t vd;
            if (awaited.size() == 0)
            begin
                $error("result transfer with no input outstanding: tdata=%h", data);
                mismatches++;
                return;
            end
            vd = awaited.pop_front();
            if (data[0] !== vd.is_prime)
            begin
                $error("is_prime: expected %0d, got %0d", vd.is_prime, data[0]);
                mismatches++;
            end
            if (data[1] !== vd.is_right_truncatable)
            begin
                $error("is_right_truncatable: expected %0d, got %0d",
                       vd.is_right_truncatable, data[1]);
                mismatches++;
            end
        endfunction
    endclass

    logic                              clk      = 1'b0;
    logic                              rst_n    = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [S_DATA_W-1:0]               s_tdata  = '0;   // value
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [rtp_pkg::OUT_BYTES_W-1:0]   m_tdata;         // is_prime, is_right_truncatable

    prime_scoreboard sb = new();
    int unsigned     stall_left;
    int unsigned     idle_cycles;
    bit              rx_quiet;

    right_truncatable_prime_check #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // leading prime digit followed by odd non-five digits
    function automatic logic [VALUE_BITS-1:0] truncatable_shape();
        logic [VALUE_BITS-1:0] n;
        n = LEAD_DIGITS[$urandom_range(0, 3)];
        repeat ($urandom_range(1, 4))
            n = n * 10 + TAIL_DIGITS[$urandom_range(0, 3)];
        return n;
    endfunction

    // wide value with a small factor, so the block settles quickly
    function automatic logic [VALUE_BITS-1:0] wide_composite();
        logic [VALUE_BITS-1:0] n;
        n = $urandom;
        if ($urandom_range(0, 1))
            n[0] = 1'b0;
        else
            n = n - (n % 3);
        return n;
    endfunction

    task automatic send_value(input logic [VALUE_BITS-1:0] v, input bit no_gaps);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(v);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_value(v);
        gap = no_gaps ? 0 : gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    // result side: checking, back-pressure and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                sb.check_verdict(m_tdata);
                rx_quiet = ($urandom_range(0, 4) == 0);
            end
            if (stall_left == 0 && !rx_quiet && $urandom_range(0, 3) == 0)
                stall_left = gap_len();
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        bit tx_quiet;
        tx_quiet = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (CORNER_VALUES[i])
            send_value(CORNER_VALUES[i], 1'b0);

        // hold off the sender until every result is back
        s_tvalid <= 1'b0;
        wait_results_drained();

        for (int i = 0; i < RANDOM_VALUES; i++)
        begin
            if ($urandom_range(0, 14) == 0)
                tx_quiet = !tx_quiet;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_value($urandom_range(0, 9999), tx_quiet);
                5, 6:          send_value(truncatable_shape(), tx_quiet);
                7:             send_value($urandom_range(0, 99), tx_quiet);
                default:       send_value(wide_composite(), tx_quiet);
            endcase
        end
        s_tvalid <= 1'b0;

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: right_truncatable_prime_check.f
rtl/core/rtp_pkg.sv
rtl/core/rtp_div.sv
rtl/core/right_truncatable_prime_check.sv
tb/sv/tb_right_truncatable_prime_check.sv
